/* design/websocket_frame_deframer_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WSFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsfd assertion failed");

// Next-cycle implication, disabled during reset.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsfd assertion failed");

`endif

/* design/wsfd_pkg.sv */
package wsfd_pkg;

   typedef enum logic [2:0] {
      PHASE_HDR0 = 3'd0,
      PHASE_HDR1 = 3'd1,
      PHASE_EXT  = 3'd2,
      PHASE_MASK = 3'd3,
      PHASE_DATA = 3'd4
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_FRAGMENT = 2'd1;
   localparam logic [1:0] ERR_LENGTH   = 2'd2;

   localparam logic [6:0]  LEN_CODE_16       = 7'd126;
   localparam logic [6:0]  LEN_CODE_64       = 7'd127;
   localparam logic [2:0]  EXT_COUNT_16      = 3'd1;
   localparam logic [2:0]  EXT_COUNT_64      = 3'd7;
   localparam logic [2:0]  MASK_COUNT        = 3'd3;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;
   localparam logic [15:0] LENGTH_SATURATED  = 16'hFFFF;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] max_payload_bytes;
   } csr_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  payload_byte;
      logic [3:0]  frame_opcode;
      logic [15:0] frame_length;
      logic        is_last;
      logic [1:0]  error_code;
   } rsp_type;

endpackage

/* design/wsfd_stream_if.sv */
interface wsfd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/websocket_frame_deframer_core.sv */
// A result appears on rsp_chan in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; header bytes, mask bytes and
// payload bytes all pass through one parser step with a single output register.
// req_chan stalls only while a held result is not taken.
// Reset (synchronous): parser expects header byte 0, limit returns to 4096.
module websocket_frame_deframer_core (
   input logic          clock,
   input logic          reset,
   wsfd_stream_if.sink   req_chan,
   wsfd_stream_if.source rsp_chan,
   wsfd_stream_if.sink   csr_chan
);

   logic [15:0]       max_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   wsfd_pkg::rsp_type rsp_data_ff;
   wsfd_pkg::rsp_type res;
   wsfd_pkg::req_type req_data;
   wsfd_pkg::csr_type csr_data;
   logic              res_valid;
   logic              out_free;
   logic              step;

   assign req_data         = req_chan.payload;
   assign csr_data         = csr_chan.payload;
   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready   = out_free;
   assign csr_chan.ready   = 1'b1;
   assign step             = req_chan.valid && out_free;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   wsfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (req_data.rx_byte),
      .max_payload (max_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_ff       <= wsfd_pkg::MAX_PAYLOAD_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            max_ff <= csr_data.max_payload_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_data_ff <= res;
      end
   end

endmodule

/* design/wsfd_parser.sv */
module wsfd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic [15:0]      max_payload,
   output logic             res_valid,
   output wsfd_pkg::rsp_type res
);

   wsfd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [15:0] len_ff, len_in;
   logic        ovf_ff, ovf_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] key_ff, key_in;
   logic [15:0] index_ff, index_in;

   logic        do_check;
   logic [15:0] chk_len;
   logic        chk_ovf;
   logic [6:0]  code;
   logic [7:0]  key_byte;
   logic        last;

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      index_in  = index_ff;
      res_valid = 1'b0;
      res       = '0;
      res.frame_opcode = opcode_ff;
      do_check  = 1'b0;
      chk_len   = '0;
      chk_ovf   = 1'b0;
      code      = rx_byte[6:0];
      key_byte  = '0;
      last      = 1'b0;

      case (phase_ff)
         wsfd_pkg::PHASE_HDR1: begin
            if (!len_ff[0] || !rx_byte[7]) begin
               res_valid        = 1'b1;
               res.result_kind  = wsfd_pkg::KIND_ERROR;
               res.frame_length = {9'd0, code};
               res.is_last      = 1'b1;
               res.error_code   = wsfd_pkg::ERR_FRAGMENT;
               phase_in         = wsfd_pkg::PHASE_HDR0;
            end else if (code == wsfd_pkg::LEN_CODE_16 || code == wsfd_pkg::LEN_CODE_64) begin
               len_in   = '0;
               ovf_in   = 1'b0;
               count_in = (code == wsfd_pkg::LEN_CODE_16) ?
                          wsfd_pkg::EXT_COUNT_16 : wsfd_pkg::EXT_COUNT_64;
               phase_in = wsfd_pkg::PHASE_EXT;
            end else begin
               do_check = 1'b1;
               chk_len  = {9'd0, code};
               chk_ovf  = 1'b0;
            end
         end
         wsfd_pkg::PHASE_EXT: begin
            chk_len = {len_ff[7:0], rx_byte};
            chk_ovf = ovf_ff | (len_ff[15:8] != 8'd0);
            if (count_ff == 3'd0) begin
               do_check = 1'b1;
            end else begin
               len_in   = chk_len;
               ovf_in   = chk_ovf;
               count_in = count_ff - 3'd1;
            end
         end
         wsfd_pkg::PHASE_MASK: begin
            key_in = {key_ff[23:0], rx_byte};
            if (count_ff != 3'd0) begin
               count_in = count_ff - 3'd1;
            end else begin
               index_in = '0;
               if (len_ff == 16'd0 && !ovf_ff) begin
                  res_valid       = 1'b1;
                  res.result_kind = wsfd_pkg::KIND_EMPTY;
                  res.is_last     = 1'b1;
                  phase_in        = wsfd_pkg::PHASE_HDR0;
               end else begin
                  phase_in = wsfd_pkg::PHASE_DATA;
               end
            end
         end
         wsfd_pkg::PHASE_DATA: begin
            case (index_ff[1:0])
               2'd0:    key_byte = key_ff[31:24];
               2'd1:    key_byte = key_ff[23:16];
               2'd2:    key_byte = key_ff[15:8];
               default: key_byte = key_ff[7:0];
            endcase
            last             = ({1'b0, index_ff} + 17'd1) >= {1'b0, len_ff};
            res_valid        = 1'b1;
            res.result_kind  = wsfd_pkg::KIND_PAYLOAD;
            res.payload_byte = rx_byte ^ key_byte;
            res.frame_length = ovf_ff ? wsfd_pkg::LENGTH_SATURATED : len_ff;
            res.is_last      = last;
            index_in         = index_ff + 16'd1;
            if (last) begin
               phase_in = wsfd_pkg::PHASE_HDR0;
            end
         end
         default: begin
            opcode_in = rx_byte[3:0];
            len_in    = {15'd0, rx_byte[7]};
            ovf_in    = 1'b0;
            phase_in  = wsfd_pkg::PHASE_HDR1;
         end
      endcase

      if (do_check) begin
         len_in = chk_len;
         ovf_in = chk_ovf;
         if (chk_ovf || chk_len > max_payload) begin
            res_valid        = 1'b1;
            res.result_kind  = wsfd_pkg::KIND_ERROR;
            res.frame_length = chk_ovf ? wsfd_pkg::LENGTH_SATURATED : chk_len;
            res.is_last      = 1'b1;
            res.error_code   = wsfd_pkg::ERR_LENGTH;
            phase_in         = wsfd_pkg::PHASE_HDR0;
         end else begin
            phase_in = wsfd_pkg::PHASE_MASK;
            count_in = wsfd_pkg::MASK_COUNT;
            key_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsfd_pkg::PHASE_HDR0;
         opcode_ff <= '0;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         count_ff  <= '0;
         key_ff    <= '0;
         index_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         index_ff  <= index_in;
      end
   end

endmodule

/* design/wsfd_checker.sv */
`include "websocket_frame_deframer_core_defines.svh"

module wsfd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wsfd_pkg::rsp_type rsp_data
);

   logic held;
   logic kind_ok;
   logic kind_err;
   logic code_set;
   logic non_payload;
   logic closing_ok;

   assign held        = rsp_valid && !rsp_ready;
   assign kind_ok     = rsp_data.result_kind <= wsfd_pkg::KIND_ERROR;
   assign kind_err    = rsp_data.result_kind == wsfd_pkg::KIND_ERROR;
   assign code_set    = rsp_data.error_code != wsfd_pkg::ERR_NONE;
   assign non_payload = rsp_valid && rsp_data.result_kind != wsfd_pkg::KIND_PAYLOAD;
   assign closing_ok  = rsp_data.is_last && rsp_data.payload_byte == 8'd0;

   `WSFD_ASSERT_NEXT(a_rsp_hold, clock, reset, held, rsp_valid && $stable(rsp_data))
   `WSFD_ASSERT_NOW(a_kind_known, clock, reset, rsp_valid, kind_ok)
   `WSFD_ASSERT_NOW(a_err_kind, clock, reset, rsp_valid, kind_err == code_set)
   `WSFD_ASSERT_NOW(a_nonpayload_last, clock, reset, non_payload, closing_ok)

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.payload)
);

/* sim/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;

   wsfd_stream_if #(.payload_type(wsfd_pkg::req_type)) req_if ();
   wsfd_stream_if #(.payload_type(wsfd_pkg::rsp_type)) rsp_if ();
   wsfd_stream_if #(.payload_type(wsfd_pkg::csr_type)) csr_if ();

   websocket_frame_deframer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   wsfd_pkg::phase_type dec_phase  = wsfd_pkg::PHASE_HDR0;
   logic [3:0]  dec_opcode = '0;
   logic [63:0] dec_length = '0;
   logic [2:0]  dec_count  = '0;
   logic [31:0] dec_key    = '0;
   logic [15:0] dec_index  = '0;
   logic [15:0] max_len_reg = wsfd_pkg::MAX_PAYLOAD_RESET;

   wsfd_pkg::rsp_type expected_rsps[$];
   int      mismatch_count  = 0;
   int      sent_count      = 0;
   int      rsp_hold_cycles = 0;
   bit      gaps_enabled    = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic wsfd_pkg::rsp_type make_rsp(input logic [1:0] kind,
                                                  input logic [7:0] data,
                                                  input logic [63:0] len, input logic last,
                                                  input logic [1:0] err);
      wsfd_pkg::rsp_type r;
      r.result_kind  = kind;
      r.payload_byte = data;
      r.frame_opcode = dec_opcode;
      r.frame_length = (len > 64'h0000_0000_0000_FFFF) ? wsfd_pkg::LENGTH_SATURATED
                                                        : len[15:0];
      r.is_last      = last;
      r.error_code   = err;
      return r;
   endfunction

   function automatic bit check_length(output wsfd_pkg::rsp_type r);
      r = '0;
      if (dec_length > {48'd0, max_len_reg}) begin
         r = make_rsp(wsfd_pkg::KIND_ERROR, 8'd0, dec_length, 1'b1, wsfd_pkg::ERR_LENGTH);
         dec_phase = wsfd_pkg::PHASE_HDR0;
         return 1'b1;
      end
      dec_phase = wsfd_pkg::PHASE_MASK;
      dec_count = wsfd_pkg::MASK_COUNT;
      dec_key   = '0;
      return 1'b0;
   endfunction

   function automatic bit deframe_step(input logic [7:0] b, output wsfd_pkg::rsp_type r);
      logic [6:0] code;
      logic [7:0] kb;
      logic       last;
      r = '0;
      case (dec_phase)
         wsfd_pkg::PHASE_HDR1: begin
            code = b[6:0];
            if (!dec_length[0] || !b[7]) begin
               r = make_rsp(wsfd_pkg::KIND_ERROR, 8'd0, {57'd0, code}, 1'b1,
                            wsfd_pkg::ERR_FRAGMENT);
               dec_phase = wsfd_pkg::PHASE_HDR0;
               return 1'b1;
            end
            if (code == wsfd_pkg::LEN_CODE_16 || code == wsfd_pkg::LEN_CODE_64) begin
               dec_length = '0;
               dec_count  = (code == wsfd_pkg::LEN_CODE_16) ? wsfd_pkg::EXT_COUNT_16
                                                            : wsfd_pkg::EXT_COUNT_64;
               dec_phase  = wsfd_pkg::PHASE_EXT;
               return 1'b0;
            end
            dec_length = {57'd0, code};
            return check_length(r);
         end
         wsfd_pkg::PHASE_EXT: begin
            dec_length = {dec_length[55:0], b};
            if (dec_count == 3'd0) begin
               return check_length(r);
            end
            dec_count = dec_count - 3'd1;
            return 1'b0;
         end
         wsfd_pkg::PHASE_MASK: begin
            dec_key = {dec_key[23:0], b};
            if (dec_count != 3'd0) begin
               dec_count = dec_count - 3'd1;
               return 1'b0;
            end
            dec_index = '0;
            if (dec_length == 64'd0) begin
               r = make_rsp(wsfd_pkg::KIND_EMPTY, 8'd0, 64'd0, 1'b1, wsfd_pkg::ERR_NONE);
               dec_phase = wsfd_pkg::PHASE_HDR0;
               return 1'b1;
            end
            dec_phase = wsfd_pkg::PHASE_DATA;
            return 1'b0;
         end
         wsfd_pkg::PHASE_DATA: begin
            case (dec_index[1:0])
               2'd0: kb = dec_key[31:24];
               2'd1: kb = dec_key[23:16];
               2'd2: kb = dec_key[15:8];
               default: kb = dec_key[7:0];
            endcase
            last = (({48'd0, dec_index} + 64'd1) >= dec_length);
            r = make_rsp(wsfd_pkg::KIND_PAYLOAD, b ^ kb, dec_length, last, wsfd_pkg::ERR_NONE);
            dec_index = dec_index + 16'd1;
            if (last) begin
               dec_phase = wsfd_pkg::PHASE_HDR0;
            end
            return 1'b1;
         end
         default: begin
            dec_opcode = b[3:0];
            dec_length = {63'd0, b[7]};
            dec_phase  = wsfd_pkg::PHASE_HDR1;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic string format_rsp(input wsfd_pkg::rsp_type r);
      return $sformatf("kind %0d byte %02h opcode %0h length %0d last %0d error %0d",
                       r.result_kind, r.payload_byte, r.frame_opcode, r.frame_length,
                       r.is_last, r.error_code);
   endfunction

   always @(posedge clock) begin : check_rsp
      wsfd_pkg::rsp_type want;
      wsfd_pkg::rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: %s", format_rsp(got));
            end
         end else begin
            want = expected_rsps[0];
            expected_rsps.delete(0);
            if (got.result_kind !== want.result_kind || got.payload_byte !== want.payload_byte ||
                got.frame_opcode !== want.frame_opcode ||
                got.frame_length !== want.frame_length || got.is_last !== want.is_last ||
                got.error_code !== want.error_code) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected %s", format_rsp(want));
                  $display("          actual   %s", format_rsp(got));
               end
            end
         end
      end
   end

   initial begin : rsp_sink
      int stall;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = rsp_hold_cycles + (gaps_enabled ? $urandom_range(0, 10) : 0);
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   task automatic send_request(input logic [7:0] b);
      int                gap;
      wsfd_pkg::rsp_type r;
      gap = gaps_enabled ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
      if (deframe_step(b, r)) begin
         expected_rsps = {expected_rsps, r};
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      wait_idle();
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.payload.max_payload_bytes <= value;
      do @(posedge clock); while (!csr_if.ready);
      max_len_reg = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // enc: 0 seven-bit length, 1 sixteen-bit extended, 2 sixty-four-bit extended
   task automatic drive_ws_frame(input logic fin, input logic masked, input logic [3:0] opc,
                                 input logic [63:0] len, input int enc,
                                 input logic [31:0] key);
      logic [7:0] hdr[14];
      int         n_hdr;
      logic [6:0] code;
      n_hdr = 0;
      hdr[n_hdr] = {fin, 3'($urandom_range(0, 7)), opc};
      n_hdr++;
      case (enc)
         0: code = len[6:0];
         1: code = wsfd_pkg::LEN_CODE_16;
         default: code = wsfd_pkg::LEN_CODE_64;
      endcase
      hdr[n_hdr] = {masked, code};
      n_hdr++;
      if (enc == 1) begin
         hdr[n_hdr] = len[15:8];
         n_hdr++;
         hdr[n_hdr] = len[7:0];
         n_hdr++;
      end else if (enc != 0) begin
         for (int i = 7; i >= 0; i--) begin
            hdr[n_hdr] = len[8*i +: 8];
            n_hdr++;
         end
      end
      for (int i = 3; i >= 0; i--) begin
         hdr[n_hdr] = key[8*i +: 8];
         n_hdr++;
      end
      for (int i = 0; i < n_hdr; i++) begin
         send_request(hdr[i]);
         if (dec_phase == wsfd_pkg::PHASE_HDR0) return;
      end
      while (dec_phase == wsfd_pkg::PHASE_DATA) send_request(8'($urandom_range(0, 255)));
   endtask

   // keep extended lengths short so garbage never opens a huge frame
   task automatic send_noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (dec_phase == wsfd_pkg::PHASE_EXT) begin
         b = (dec_count == 3'd0) ? (b & 8'h3F) : 8'h00;
      end
      send_request(b);
   endtask

   task automatic run_random_traffic(input int n_bytes);
      int          stop_at;
      int          pick;
      int          v;
      int          enc;
      logic [63:0] len;
      stop_at = sent_count + n_bytes;
      while (sent_count < stop_at) begin
         gaps_enabled = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               len = 64'($urandom_range(0, 8));
            end else if (pick < 65) begin
               len = 64'($urandom_range(9, 125));
            end else if (pick < 80 && max_len_reg <= 16'd200) begin
               v = int'(max_len_reg) + int'($urandom_range(0, 2)) - 1;
               if (v < 0) v = 0;
               len = 64'(v);
            end else if (pick < 80) begin
               len = 64'($urandom_range(126, 300));
            end else if (pick < 90 && max_len_reg != 16'hFFFF) begin
               len = 64'($urandom_range(int'(max_len_reg) + 1, 65535));
            end else begin
               len = {$urandom, $urandom} | 64'h0000_0000_0001_0000;
            end
            if (len <= 64'd125) begin
               enc = $urandom_range(0, 2);
            end else if (len <= 64'd65535) begin
               enc = $urandom_range(1, 2);
            end else begin
               enc = 2;
            end
            drive_ws_frame(1'b1, 1'b1, 4'($urandom_range(0, 15)), len, enc, $urandom);
         end else if (pick < 88) begin
            v = $urandom_range(0, 2);
            drive_ws_frame(v == 1, v == 0, 4'($urandom_range(0, 15)),
                           64'($urandom_range(0, 125)), $urandom_range(0, 2), $urandom);
            repeat ($urandom_range(0, 6)) send_noise_byte();
         end else begin
            repeat ($urandom_range(1, 6)) send_noise_byte();
         end
         while (dec_phase != wsfd_pkg::PHASE_HDR0) send_noise_byte();
      end
      gaps_enabled = 1'b1;
   endtask

   task automatic test_directed_frames();
      drive_ws_frame(1'b0, 1'b1, 4'h0, 64'd5, 0, 32'h1234_5678);
      drive_ws_frame(1'b1, 1'b0, 4'hF, 64'd0, 2, 32'h0000_0000);
      drive_ws_frame(1'b1, 1'b1, 4'h9, 64'd0, 0, 32'hDEAD_BEEF);
      drive_ws_frame(1'b1, 1'b1, 4'h1, 64'd5, 0, 32'h0102_0380);
      drive_ws_frame(1'b1, 1'b1, 4'h2, 64'h0000_0000_0000_FFFF, 1, 32'hFFFF_FFFF);
      drive_ws_frame(1'b1, 1'b1, 4'hA, 64'hFFFF_FFFF_FFFF_FFFF, 2, 32'hA5A5_5A5A);
      wait_idle();
   endtask

   task automatic test_limit_sweep();
      logic [15:0] limits[6];
      limits[0] = 16'd0;
      limits[1] = 16'd1;
      limits[2] = 16'hFFFF;
      limits[3] = 16'($urandom_range(2, 200));
      limits[4] = 16'($urandom_range(201, 65534));
      limits[5] = wsfd_pkg::MAX_PAYLOAD_RESET;
      foreach (limits[i]) begin
         write_limit(limits[i]);
         run_random_traffic(240);
         wait_idle();
      end
   endtask

   task automatic test_backpressure();
      gaps_enabled = 1'b0;
      rsp_hold_cycles = 150;
      drive_ws_frame(1'b1, 1'b1, 4'h2, 64'd120, 0, $urandom);
      run_random_traffic(60);
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_limit_sweep();
      test_backpressure();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
